// File: hdl/dadjd_pkg.sv
// ============================================================================
// dadjd_pkg
// Constants and lookup tables for the date shifter: day-number base, the
// month-offset tables and the reciprocal multipliers for constant divisions.
// ============================================================================
`default_nettype none

package dadjd_pkg;

    // Day number of the calendar origin used by the forward conversion
    localparam int unsigned JDN_BASE = 1720995;

    // Last day number handled by the Julian calendar on the way back
    localparam int unsigned GREG_SWITCH = 2299160;

    // Offsets used by the reverse conversion
    localparam int unsigned GREG_BIAS  = 7468865;
    localparam int unsigned B_BIAS     = 1524;
    localparam int unsigned C_BIAS     = 2442;
    localparam int unsigned YEAR_LATE  = 4716;
    localparam int unsigned YEAR_EARLY = 4715;

    // Days in four Julian years; the term is taken as (1461 * x) / 4
    localparam int unsigned QUAD_DAYS = 1461;

    // year / 100 as (year * 5243) >> 19, exact for year below 43699
    localparam logic [12:0] CENT_MUL = 13'd5243;

    // x / 146097 for x below 2^26: ceil(2^44 / 146097), shift 44
    localparam logic [63:0] GREG_MUL_FULL = ((64'd1 << 44) + 64'd146096) / 64'd146097;
    localparam logic [26:0] GREG_MUL      = GREG_MUL_FULL[26:0];

    // x / 7305 for x below 2^28: ceil(2^41 / 7305), shift 41
    localparam logic [63:0] YEAR_MUL_FULL = ((64'd1 << 41) + 64'd7304) / 64'd7305;
    localparam logic [28:0] YEAR_MUL      = YEAR_MUL_FULL[28:0];

    // (10000 * r) / 306001 for r below 512: ceil(10000 * 2^32 / 306001), shift 32
    localparam logic [63:0] MONTH_MUL_FULL =
        ((64'd10000 << 32) + 64'd306000) / 64'd306001;
    localparam logic [27:0] MONTH_MUL      = MONTH_MUL_FULL[27:0];

    // (306001 * (m + 1)) / 10000, indexed by the raw month; months 0..2
    // are taken as 12..14 of the previous year
    localparam logic [8:0] MONTH_START [16] = '{
        9'd397, 9'd428, 9'd459, 9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
        9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
    };

    // (e * 306001) / 10000 for the reverse month index e
    localparam logic [8:0] MONTH_DAYS [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

endpackage

`default_nettype wire

// File: hdl/date_add_days_julian_day_top.sv
// ============================================================================
// date_add_days_julian_day_top
// Converts a calendar date to its day number, adds a signed day offset and
// converts the sum back to day, month and year in an eleven-stage pipeline.
// ============================================================================
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | in_valid  / in_stall      | in_day, in_month, in_year, day_offset
//  out     | out_valid / out_stall     | out_day, out_month, out_year,
//          |                           | day_number
//
//  One date per cycle while out_stall is low.
//  The rate is set by the pipeline: each stage holds one constant multiply
//  (reciprocal division) or one wide add, and every stage takes a new item.
//  Each stage has its own valid bit and loads whenever it is empty or the
//  stage after it moves, so bubbles close up under a stall.
//  in_stall rises only when all stages are full and out_stall is high.
//  Reset clears the valid bits only; data registers are not reset.
//
`default_nettype none

module date_add_days_julian_day_top (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [4:0]         in_day,
    input  wire logic [3:0]         in_month,
    input  wire logic [13:0]        in_year,
    input  wire logic signed [20:0] day_offset,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [4:0]              out_day,
    output logic [3:0]              out_month,
    output logic signed [14:0]      out_year,
    output logic [22:0]             day_number
);

    import dadjd_pkg::*;

    localparam int NS = 11;

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [NS:1] valid_reg;
    logic [NS:1] valid_next;
    logic [NS:1] ready;

    // A stage may load when it is empty or its content moves on
    always_comb
    begin
        ready[NS] = !valid_reg[NS] || !out_stall;
        for (int k = NS - 1; k >= 1; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k + 1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ready[1])
        begin
            valid_next[1] = in_valid;
        end
        for (int k = 2; k <= NS; k++)
        begin
            if (ready[k])
            begin
                valid_next[k] = valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready[1];
    assign out_valid = valid_reg[NS];

    // ------------------------------------------------------------------
    // Stage 1: move January and February into the previous year, century
    // ------------------------------------------------------------------
    logic               month_low;
    logic               year_neg;
    logic [13:0]        year_adj;
    logic [26:0]        cent_prod;

    logic [13:0]        s1_year_reg;
    logic               s1_neg_reg;
    logic [7:0]         s1_cent_reg;
    logic [8:0]         s1_mterm_reg;
    logic [4:0]         s1_day_reg;
    logic signed [20:0] s1_off_reg;

    always_comb
    begin
        month_low = (in_month <= 4'd2);
        // year zero in January or February gives year minus one
        year_neg  = month_low && (in_year == 14'd0);
        if (month_low && !year_neg)
        begin
            year_adj = in_year - 14'd1;
        end
        else if (year_neg)
        begin
            year_adj = 14'd0;
        end
        else
        begin
            year_adj = in_year;
        end
        cent_prod = 27'(year_adj) * 27'(CENT_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            s1_year_reg  <= year_adj;
            s1_neg_reg   <= year_neg;
            s1_cent_reg  <= cent_prod[26:19];
            s1_mterm_reg <= MONTH_START[in_month];
            s1_day_reg   <= in_day;
            s1_off_reg   <= day_offset;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: year term and century correction
    // ------------------------------------------------------------------
    logic [24:0]        year_prod;
    logic signed [23:0] yterm;
    logic signed [10:0] small_sum;

    logic signed [23:0] s2_yterm_reg;
    logic signed [10:0] s2_small_reg;
    logic signed [20:0] s2_off_reg;

    always_comb
    begin
        year_prod = 25'(s1_year_reg) * 25'(QUAD_DAYS);
        // (1461 * -1) / 4 truncates to -365
        if (s1_neg_reg)
        begin
            yterm = -24'sd365;
        end
        else
        begin
            yterm = $signed({1'b0, year_prod[24:2]});
        end
        small_sum = $signed(11'(s1_mterm_reg)) + $signed(11'(s1_day_reg)) + 11'sd2
                  + $signed(11'(s1_cent_reg[7:2])) - $signed(11'(s1_cent_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            s2_yterm_reg <= yterm;
            s2_small_reg <= small_sum;
            s2_off_reg   <= s1_off_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: day number of the input date
    // ------------------------------------------------------------------
    logic signed [24:0] jdn_sum;

    logic [22:0]        s3_jdn_reg;
    logic signed [20:0] s3_off_reg;

    assign jdn_sum = 25'(s2_yterm_reg) + $signed(25'(JDN_BASE)) + 25'(s2_small_reg);

    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            s3_jdn_reg <= jdn_sum[22:0];
            s3_off_reg <= s2_off_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add the offset, pick the calendar
    // ------------------------------------------------------------------
    logic signed [24:0] shift_sum;

    logic [23:0]        s4_j_reg;
    logic               s4_greg_reg;
    logic [22:0]        s4_jdn_reg;

    assign shift_sum = $signed({2'b00, s3_jdn_reg}) + 25'(s3_off_reg);

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            s4_j_reg    <= shift_sum[23:0];
            s4_greg_reg <= (shift_sum > $signed(25'(GREG_SWITCH)));
            s4_jdn_reg  <= s3_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Gregorian cycles, (4j - 7468865) / 146097
    // ------------------------------------------------------------------
    logic [25:0] greg_x;
    logic [52:0] greg_prod;

    logic [8:0]  s5_g0_reg;
    logic [23:0] s5_j_reg;
    logic        s5_greg_reg;
    logic [22:0] s5_jdn_reg;

    always_comb
    begin
        greg_x    = {s4_j_reg, 2'b00} - 26'(GREG_BIAS);
        greg_prod = 53'(greg_x) * 53'(GREG_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (ready[5])
        begin
            s5_g0_reg   <= greg_prod[52:44];
            s5_j_reg    <= s4_j_reg;
            s5_greg_reg <= s4_greg_reg;
            s5_jdn_reg  <= s4_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: corrected day count b
    // ------------------------------------------------------------------
    logic [24:0] greg_corr;
    logic [24:0] b_sum;

    logic [23:0] s6_b_reg;
    logic [22:0] s6_jdn_reg;

    always_comb
    begin
        if (s5_greg_reg)
        begin
            greg_corr = 25'(s5_g0_reg) - 25'(s5_g0_reg[8:2]) + 25'd1;
        end
        else
        begin
            greg_corr = '0;
        end
        b_sum = 25'(s5_j_reg) + greg_corr + 25'(B_BIAS);
    end

    always_ff @(posedge clk)
    begin
        if (ready[6])
        begin
            s6_b_reg   <= b_sum[23:0];
            s6_jdn_reg <= s5_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: 20b - 2442
    // ------------------------------------------------------------------
    logic [27:0] xc;

    logic [27:0] s7_xc_reg;
    logic [23:0] s7_b_reg;
    logic [22:0] s7_jdn_reg;

    assign xc = {s6_b_reg, 4'b0000} + 28'({s6_b_reg, 2'b00}) - 28'(C_BIAS);

    always_ff @(posedge clk)
    begin
        if (ready[7])
        begin
            s7_xc_reg  <= xc;
            s7_b_reg   <= s6_b_reg;
            s7_jdn_reg <= s6_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: year count c = (20b - 2442) / 7305
    // ------------------------------------------------------------------
    logic [56:0] year_div_prod;

    logic [15:0] s8_c_reg;
    logic [23:0] s8_b_reg;
    logic [22:0] s8_jdn_reg;

    assign year_div_prod = 57'(s7_xc_reg) * 57'(YEAR_MUL);

    always_ff @(posedge clk)
    begin
        if (ready[8])
        begin
            s8_c_reg   <= year_div_prod[56:41];
            s8_b_reg   <= s7_b_reg;
            s8_jdn_reg <= s7_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: days into the year, r = b - (1461c) / 4
    // ------------------------------------------------------------------
    logic [26:0] dd_prod;
    logic [24:0] r_diff;

    logic [8:0]  s9_r_reg;
    logic [15:0] s9_c_reg;
    logic [22:0] s9_jdn_reg;

    always_comb
    begin
        dd_prod = 27'(s8_c_reg) * 27'(QUAD_DAYS);
        r_diff  = 25'(s8_b_reg) - dd_prod[26:2];
    end

    always_ff @(posedge clk)
    begin
        if (ready[9])
        begin
            s9_r_reg   <= r_diff[8:0];
            s9_c_reg   <= s8_c_reg;
            s9_jdn_reg <= s8_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: month index e = (10000r) / 306001
    // ------------------------------------------------------------------
    logic [36:0] e_prod;

    logic [3:0]  s10_e_reg;
    logic [8:0]  s10_r_reg;
    logic [15:0] s10_c_reg;
    logic [22:0] s10_jdn_reg;

    assign e_prod = 37'(s9_r_reg) * 37'(MONTH_MUL);

    always_ff @(posedge clk)
    begin
        if (ready[10])
        begin
            s10_e_reg   <= e_prod[35:32];
            s10_r_reg   <= s9_r_reg;
            s10_c_reg   <= s9_c_reg;
            s10_jdn_reg <= s9_jdn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: day, month and year into the output register
    // ------------------------------------------------------------------
    logic [8:0]         day_diff;
    logic [3:0]         month_calc;
    logic signed [16:0] year_calc;

    logic [4:0]         day_out_reg;
    logic [3:0]         month_out_reg;
    logic signed [14:0] year_out_reg;
    logic [22:0]        jdn_out_reg;

    always_comb
    begin
        day_diff = s10_r_reg - MONTH_DAYS[s10_e_reg];
        if (s10_e_reg <= 4'd13)
        begin
            month_calc = s10_e_reg - 4'd1;
        end
        else
        begin
            month_calc = s10_e_reg - 4'd13;
        end
        if (month_calc > 4'd2)
        begin
            year_calc = $signed(17'(s10_c_reg)) - $signed(17'(YEAR_LATE));
        end
        else
        begin
            year_calc = $signed(17'(s10_c_reg)) - $signed(17'(YEAR_EARLY));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[11])
        begin
            day_out_reg   <= day_diff[4:0];
            month_out_reg <= month_calc;
            year_out_reg  <= year_calc[14:0];
            jdn_out_reg   <= s10_jdn_reg;
        end
    end

    assign out_day    = day_out_reg;
    assign out_month  = month_out_reg;
    assign out_year   = year_out_reg;
    assign day_number = jdn_out_reg;

endmodule

`default_nettype wire

// File: hdl/dadjd_checker.sv
// ============================================================================
// dadjd_checker
// Port-level checks for the date shifter, bound to the top level.
// ============================================================================
`default_nettype none

module dadjd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [4:0]         in_day,
    input wire logic [3:0]         in_month,
    input wire logic [13:0]        in_year,
    input wire logic signed [20:0] day_offset,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [4:0]         out_day,
    input wire logic [3:0]         out_month,
    input wire logic signed [14:0] out_year,
    input wire logic [22:0]        day_number
);

    // A result held under stall stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A result held under stall keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_day) && $stable(out_month)
                                   && $stable(out_year) && $stable(day_number))
        else $error("result payload changed while stalled");

    // The pipeline pushes back only when full and blocked at the output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    // The reverse conversion always lands on a real month
    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_month >= 4'd1 && out_month <= 4'd12)
        else $error("month out of range");

    // The day of month is never zero
    a_day: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_day != 5'd0)
        else $error("day of month is zero");

endmodule

bind date_add_days_julian_day_top dadjd_checker u_dadjd_checker (.*);

`default_nettype wire

// File: tb/tb_date_add_days_julian_day_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_date_add_days_julian_day_top
// Self-checking bench for the date shifter. Dates go in with a signed day
// offset; each result carries the shifted date and the day number of the
// input date. A short table covers the calendar switch, the field extremes
// and malformed day, month and year values. Random dates follow, and every
// result is compared with a local date-arithmetic model. Both channels idle
// and stall at random. One long output hold-off fills the pipeline.
// ============================================================================

module tb_date_add_days_julian_day_top;

    // Input date and day offset, as presented on the input channel
    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [20:0] offset;
    } date_req_t;

    // Shifted date plus the day number of the unshifted date
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic [22:0] number;
    } shifted_date_t;

    // One directed row; res is only used where typed is set
    typedef struct packed {
        date_req_t     req;
        logic          typed;
        shifted_date_t res;
    } date_row_t;

    localparam int NUM_DIRECTED = 22;
    localparam int NUM_RANDOM   = 530;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [4:0]         in_day     = '0;
    logic [3:0]         in_month   = '0;
    logic [13:0]        in_year    = '0;
    logic signed [20:0] day_offset = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic signed [14:0] out_year;
    logic [22:0]        day_number;

    // Expected result travelling alongside the offered input
    shifted_date_t offered_result = '0;
    shifted_date_t expected_dates [$];
    int            mismatch_count = 0;

    // Handshake between the stimulus and the output hold-off
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    date_row_t directed_rows [NUM_DIRECTED];

    date_add_days_julian_day_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_day     (in_day),
        .in_month   (in_month),
        .in_year    (in_year),
        .day_offset (day_offset),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_day    (out_day),
        .out_month  (out_month),
        .out_year   (out_year),
        .day_number (day_number)
    );

    always #2 clk = ~clk;

    // Date to day number (Gregorian rule), add offset, back to a date with
    // the Julian calendar at or below the switch day
    function automatic shifted_date_t shift_date(date_req_t req);
        longint        d, m, y, off, cent, jdn, j, g, b, c, dd, e, od, om, oy;
        shifted_date_t res;
        d   = longint'(req.day);
        m   = longint'(req.month);
        y   = longint'(req.year);
        off = longint'($signed(req.offset));
        if (m <= 2)
        begin
            y = y - 1;
            m = m + 12;
        end
        cent = y / 100;
        jdn  = (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + d + 1720995
               + 2 - cent + cent / 4;
        j = jdn + off;
        if (j > 2299160)
        begin
            g = (j * 4 - 7468865) / 146097;
            g = j + 1 + g - g / 4;
        end
        else
        begin
            g = j;
        end
        b  = g + 1524;
        c  = (b * 20 - 2442) / 7305;
        dd = (c * 1461) / 4;
        e  = (10000 * (b - dd)) / 306001;
        od = b - dd - (e * 306001) / 10000;
        om = (e <= 13) ? e - 1 : e - 13;
        oy = c - ((om > 2) ? 4716 : 4715);
        res.day    = od[4:0];
        res.month  = om[3:0];
        res.year   = oy[14:0];
        res.number = jdn[22:0];
        return res;
    endfunction

    // Mostly well-formed dates; some raw bit patterns for the malformed cases
    function automatic date_req_t random_date();
        date_req_t req;
        int        kind;
        int        spread;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            req.day    = 5'($urandom);
            req.month  = 4'($urandom);
            req.year   = 14'($urandom);
            req.offset = 21'($urandom);
        end
        else
        begin
            req.day   = 5'($urandom_range(1, (kind < 60) ? 28 : 31));
            req.month = 4'($urandom_range(1, 12));
            if (kind < 25)
                req.year = 14'($urandom_range(1550, 1620));
            else
                req.year = 14'($urandom_range(1, 9999));
            if (kind < 25)
                spread = 20000;
            else if (kind < 50)
                spread = 400;
            else
                spread = 60000;
            if (kind < 75)
                req.offset = 21'(int'($urandom_range(0, 2 * spread)) - spread);
            else
                req.offset = 21'($urandom);
        end
        return req;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one date and wait for its transfer; entered and left on a clock edge
    task automatic offer_date(input date_req_t req, input logic typed,
                              input shifted_date_t typed_res);
        in_valid       <= 1'b1;
        in_day         <= req.day;
        in_month       <= req.month;
        in_year        <= req.year;
        day_offset     <= req.offset;
        offered_result <= typed ? typed_res : shift_date(req);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Transfer monitor: check results, then record accepted inputs
    always @(posedge clk)
    begin
        shifted_date_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    $error("result with no input outstanding: %0d-%0d-%0d",
                           $signed(out_year), out_month, out_day);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (out_day !== want.day)
                    begin
                        $error("out_day: expected %0d, got %0d", want.day, out_day);
                        mismatch_count++;
                    end
                    if (out_month !== want.month)
                    begin
                        $error("out_month: expected %0d, got %0d", want.month, out_month);
                        mismatch_count++;
                    end
                    if (out_year !== want.year)
                    begin
                        $error("out_year: expected %0d, got %0d",
                               $signed(want.year), out_year);
                        mismatch_count++;
                    end
                    if (day_number !== want.number)
                    begin
                        $error("day_number: expected %0d, got %0d",
                               want.number, day_number);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_dates.insert(expected_dates.size(), offered_result);
        end
    end

    // Output side: random stall and free runs, plus one long hold-off on request
    initial
    begin : output_pacing
        int r;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (64) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(4, 60)) @(posedge clk);
                end
                else if (r < 90)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(8, 40)) @(posedge clk);
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int i;
        // Known values first: reference dates, calendar switch, extremes,
        // then malformed days, months and year zero (checked by the model)
        directed_rows = '{
        '{'{5'd1,  4'd1,  14'd2000,  21'sd0},      1'b1, '{5'd1,  4'd1,  15'sd2000, 23'd2451545}},
        '{'{5'd15, 4'd10, 14'd1582,  21'sd0},      1'b1, '{5'd15, 4'd10, 15'sd1582, 23'd2299161}},
        '{'{5'd15, 4'd10, 14'd1582,  -21'sd1},     1'b1, '{5'd4,  4'd10, 15'sd1582, 23'd2299161}},
        '{'{5'd1,  4'd1,  14'd1,     21'sd0},      1'b1, '{5'd3,  4'd1,  15'sd1,    23'd1721426}},
        '{'{5'd31, 4'd12, 14'd9999,  21'sd0},      1'b1, '{5'd31, 4'd12, 15'sd9999, 23'd5373484}},
        '{'{5'd4,  4'd10, 14'd1582,  21'sd0},      1'b0, '0},
        '{'{5'd16, 4'd10, 14'd1582,  -21'sd2},     1'b0, '0},
        '{'{5'd1,  4'd1,  14'd1,     21'h10_0000}, 1'b0, '0},
        '{'{5'd31, 4'd12, 14'd9999,  21'h0F_FFFF}, 1'b0, '0},
        '{'{5'd31, 4'd15, 14'd16383, 21'h0F_FFFF}, 1'b0, '0},
        '{'{5'd0,  4'd0,  14'd0,     21'h10_0000}, 1'b0, '0},
        '{'{5'd0,  4'd0,  14'd0,     21'sd0},      1'b0, '0},
        '{'{5'd29, 4'd2,  14'd2000,  21'sd0},      1'b0, '0},
        '{'{5'd31, 4'd2,  14'd2001,  21'sd0},      1'b0, '0},
        '{'{5'd0,  4'd3,  14'd2023,  21'sd0},      1'b0, '0},
        '{'{5'd1,  4'd0,  14'd2024,  21'sd0},      1'b0, '0},
        '{'{5'd15, 4'd13, 14'd2024,  21'sd0},      1'b0, '0},
        '{'{5'd1,  4'd3,  14'd0,     21'sd0},      1'b0, '0},
        '{'{5'd1,  4'd1,  14'd0,     21'sd0},      1'b0, '0},
        '{'{5'd1,  4'd1,  14'd1,     -21'sd400},   1'b0, '0},
        '{'{5'd31, 4'd12, 14'd1999,  21'sd1},      1'b0, '0},
        '{'{5'd28, 4'd2,  14'd1900,  21'sd1},      1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_date(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
            pause_sender(sender_gap());
        end

        // Random dates; the first quarter of each hundred goes back to back
        for (i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 2)
            begin
                // keep offering through a long output hold-off so the pipe fills
                hold_request = 1'b1;
                while (!hold_done)
                    offer_date(random_date(), 1'b0, '0);
            end
            offer_date(random_date(), 1'b0, '0);
            if ((i % 100) >= 25)
                pause_sender(sender_gap());
        end
        in_valid <= 1'b0;

        // Drain, then watch for stray results
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        if (mismatch_count == 0)
            $display("date_add_days_julian_day_top regression: pass");
        else
            $display("date_add_days_julian_day_top regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("date_add_days_julian_day_top regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/dadjd_pkg.sv
hdl/date_add_days_julian_day_top.sv
hdl/dadjd_checker.sv
tb/tb_date_add_days_julian_day_top.sv
